[rtl/sts_pkg.sv]
// Shared types, token codes and keyword trie tables for the token scanner.
// Used by every module in the scanner; depends on nothing.
`default_nettype none
package sts_pkg;

  localparam int unsigned FIELD_W = 24;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned NODES   = 61;

  localparam logic [5:0] T_LPAREN  = 6'd0;
  localparam logic [5:0] T_RPAREN  = 6'd1;
  localparam logic [5:0] T_LBRACE  = 6'd2;
  localparam logic [5:0] T_RBRACE  = 6'd3;
  localparam logic [5:0] T_COMMA   = 6'd4;
  localparam logic [5:0] T_DOT     = 6'd5;
  localparam logic [5:0] T_MINUS   = 6'd6;
  localparam logic [5:0] T_PLUS    = 6'd7;
  localparam logic [5:0] T_SEMI    = 6'd8;
  localparam logic [5:0] T_SLASH   = 6'd9;
  localparam logic [5:0] T_STAR    = 6'd10;
  localparam logic [5:0] T_BANG    = 6'd11;
  localparam logic [5:0] T_EQUAL   = 6'd13;
  localparam logic [5:0] T_GREATER = 6'd15;
  localparam logic [5:0] T_LESS    = 6'd17;
  localparam logic [5:0] T_IDENT   = 6'd19;
  localparam logic [5:0] T_STRING  = 6'd20;
  localparam logic [5:0] T_NUMBER  = 6'd21;
  localparam logic [5:0] T_ERROR   = 6'd38;
  localparam logic [5:0] T_EOF     = 6'd39;

  localparam logic [1:0] EK_NONE   = 2'd0;
  localparam logic [1:0] EK_CHAR   = 2'd1;
  localparam logic [1:0] EK_STRING = 2'd2;

  localparam logic [5:0] TRIE_ROOT = 6'd1;

  typedef enum logic [11:0] {
    M_IDLE    = 12'b000000000001,
    M_SLASH   = 12'b000000000010,
    M_COMMENT = 12'b000000000100,
    M_BANG    = 12'b000000001000,
    M_EQUAL   = 12'b000000010000,
    M_LESS    = 12'b000000100000,
    M_GREATER = 12'b000001000000,
    M_STRING  = 12'b000010000000,
    M_INT     = 12'b000100000000,
    M_DOT     = 12'b001000000000,
    M_FRAC    = 12'b010000000000,
    M_IDENT   = 12'b100000000000
  } mode_t;

  typedef struct packed {
    logic [5:0]         typ;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] line;
    logic [1:0]         ek;
    logic [7:0]         bc;
  } tok_t;

  // Up to three tokens caused by one input item.
  typedef struct packed {
    logic [1:0]     cnt;
    tok_t [2:0]     tok;
  } bundle_t;

  localparam logic [5:0] UP_NODE [NODES] = '{
    6'd0, 6'd0,
    6'd1, 6'd2, 6'd3,
    6'd1, 6'd5, 6'd6, 6'd7, 6'd8,
    6'd1, 6'd10, 6'd11, 6'd12,
    6'd1, 6'd14, 6'd15, 6'd16, 6'd17, 6'd14, 6'd19, 6'd14, 6'd21,
    6'd1, 6'd23,
    6'd1, 6'd25, 6'd26,
    6'd1, 6'd28,
    6'd1, 6'd30, 6'd31, 6'd32, 6'd33,
    6'd1, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
    6'd1, 6'd41, 6'd42, 6'd43, 6'd44,
    6'd1, 6'd46, 6'd47, 6'd48, 6'd46, 6'd50, 6'd51,
    6'd1, 6'd53, 6'd54,
    6'd1, 6'd56, 6'd57, 6'd58, 6'd59
  };

  localparam logic [7:0] UP_CHAR [NODES] = '{
    8'd0, 8'd0,
    "a", "n", "d",
    "c", "l", "a", "s", "s",
    "e", "l", "s", "e",
    "f", "a", "l", "s", "e", "o", "r", "u", "n",
    "i", "f",
    "n", "i", "l",
    "o", "r",
    "p", "r", "i", "n", "t",
    "r", "e", "t", "u", "r", "n",
    "s", "u", "p", "e", "r",
    "t", "h", "i", "s", "r", "u", "e",
    "v", "a", "r",
    "w", "h", "i", "l", "e"
  };

  // Each trie node has at most one child per byte, so the match is unique.
  function automatic logic [5:0] trie_next(input logic [5:0] node, input logic [7:0] c);
    logic [5:0] r;
    r = 6'd0;
    if (node != 6'd0) begin
      for (int i = 2; i < NODES; i++) begin
        if (UP_NODE[i] == node && UP_CHAR[i] == c) r = 6'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [5:0] accept_type(input logic [5:0] node);
    logic [5:0] r;
    case (node)
      6'd4:    r = 6'd22;
      6'd9:    r = 6'd23;
      6'd13:   r = 6'd24;
      6'd18:   r = 6'd25;
      6'd20:   r = 6'd26;
      6'd22:   r = 6'd27;
      6'd24:   r = 6'd28;
      6'd27:   r = 6'd29;
      6'd29:   r = 6'd30;
      6'd34:   r = 6'd31;
      6'd40:   r = 6'd32;
      6'd45:   r = 6'd33;
      6'd49:   r = 6'd34;
      6'd52:   r = 6'd35;
      6'd55:   r = 6'd36;
      6'd60:   r = 6'd37;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic alpha_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage
`default_nettype wire

[rtl/script_token_scanner_unit.sv]
// Top level of the token scanner: front end, bundle queue and serializer.
// Depends on sts_pkg, sts_front, sts_queue and sts_back.
//
//  Channel  Ports                                   Direction  Flow control
//  in       in_char_byte, in_end_of_source          input      in_valid / in_stall
//  out      out_token_*, out_error_kind, out_bad_char,
//           out_last_of_run                         output     out_valid / out_stall
//
// One byte is taken per cycle while the four-entry bundle queue has room.
// Each byte yields zero to three tokens; the serializer sends one per cycle while
// out_stall is low, from the bundle queue through its output register.
// Reset is synchronous and active low and needs no clearing time.
// in_stall rises only when the queue is full; out_stall holds the output register.
`default_nettype none
module script_token_scanner_unit #(
  parameter int unsigned POS_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_end_of_source,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_token_type,
  output logic [23:0]      out_token_start,
  output logic [23:0]      out_token_length,
  output logic [23:0]      out_token_line,
  output logic [1:0]       out_error_kind,
  output logic [7:0]       out_bad_char,
  output logic             out_last_of_run
);

  sts_pkg::bundle_t fb, qb;
  sts_pkg::tok_t    tok;
  logic             acc, push, pop, full, nempty;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  sts_front #(.POS_BITS(POS_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .c(in_char_byte),
    .eos(in_end_of_source), .bundle(fb), .push(push)
  );

  sts_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(fb), .pop(pop),
    .rdata(qb), .full(full), .nempty(nempty)
  );

  sts_back u_back (
    .clk(clk), .rst_n(rst_n), .head(qb), .head_valid(nempty), .pop(pop),
    .out_stall(out_stall), .out_valid(out_valid), .out_tok(tok),
    .out_last(out_last_of_run)
  );

  assign out_token_type   = tok.typ;
  assign out_token_start  = tok.start;
  assign out_token_length = tok.len;
  assign out_token_line   = tok.line;
  assign out_error_kind   = tok.ek;
  assign out_bad_char     = tok.bc;

endmodule
`default_nettype wire

[rtl/sts_front.sv]
// Scanner front end: accepts source bytes, tracks lexer state and builds
// a bundle of up to three tokens per byte. Depends on sts_pkg.
`default_nettype none
module sts_front #(
  parameter int unsigned POS_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [7:0]        c,
  input  wire logic              eos,
  output sts_pkg::bundle_t       bundle,
  output logic                   push
);

  localparam int unsigned P = POS_BITS;
  localparam logic [P-1:0] POS_MAX = '1;
  localparam logic [63:0] LIM64 = (P < 24) ? ((64'd1 << P) - 64'd1) : 64'hFFFFFF;
  localparam logic [P:0] LIM = (P+1)'(LIM64);

  sts_pkg::mode_t mode_r, mode_v;
  logic [5:0]   node_r, node_v;
  logic [P-1:0] ls_r, ls_v, pos_r, pos_v, line_r, ln_v;
  logic         eof_r, eof_v;
  logic [1:0]   n;
  logic         do_flush, do_idle;
  logic [P-1:0] d;
  logic [5:0]   k;

  function automatic logic [23:0] clampv(input logic [P:0] v);
    return (v > LIM) ? 24'(LIM) : 24'(v);
  endfunction

  function automatic logic [P:0] span(input logic [P-1:0] a, input logic [P-1:0] b);
    return (b >= a) ? (P+1)'(b - a) : '0;
  endfunction

  function automatic sts_pkg::tok_t mk(input logic [5:0] typ, input logic [P-1:0] s,
                                       input logic [P:0] len, input logic [1:0] ek,
                                       input logic [7:0] bc, input logic [P-1:0] ln);
    sts_pkg::tok_t t;
    t.typ   = typ;
    t.start = clampv({1'b0, s});
    t.len   = clampv(len);
    t.line  = clampv({1'b0, ln});
    t.ek    = ek;
    t.bc    = bc;
    return t;
  endfunction

  always_comb begin
    mode_v   = mode_r;
    node_v   = node_r;
    ls_v     = ls_r;
    pos_v    = pos_r;
    ln_v     = line_r;
    eof_v    = eof_r;
    n        = 2'd0;
    bundle   = '0;
    do_flush = 1'b0;
    do_idle  = 1'b0;
    d        = '0;
    k        = '0;
    if (eos) begin
      do_flush = !eof_r;
    end else if (!eof_r) begin
      case (mode_r)
        sts_pkg::M_SLASH: begin
          if (c == "/") mode_v = sts_pkg::M_COMMENT;
          else begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        sts_pkg::M_COMMENT: begin
          if (c == "\n") do_idle = 1'b1;
        end
        sts_pkg::M_BANG, sts_pkg::M_EQUAL, sts_pkg::M_LESS, sts_pkg::M_GREATER: begin
          if (c == "=") begin
            case (mode_r)
              sts_pkg::M_BANG:  k = sts_pkg::T_BANG;
              sts_pkg::M_EQUAL: k = sts_pkg::T_EQUAL;
              sts_pkg::M_LESS:  k = sts_pkg::T_LESS;
              default:          k = sts_pkg::T_GREATER;
            endcase
            bundle.tok[n] = mk(k + 6'd1, ls_r, span(ls_r, pos_r) + (P+1)'(1),
                               sts_pkg::EK_NONE, 8'd0, ln_v);
            n = n + 2'd1;
            mode_v = sts_pkg::M_IDLE;
            node_v = sts_pkg::TRIE_ROOT;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        sts_pkg::M_STRING: begin
          if (c == "\"") begin
            bundle.tok[n] = mk(sts_pkg::T_STRING, ls_r, span(ls_r, pos_r) + (P+1)'(1),
                               sts_pkg::EK_NONE, 8'd0, ln_v);
            n = n + 2'd1;
            mode_v = sts_pkg::M_IDLE;
            node_v = sts_pkg::TRIE_ROOT;
          end else if (c == "\n" && line_r < POS_MAX) begin
            ln_v = line_r + P'(1);
          end
        end
        sts_pkg::M_INT: begin
          if (c == ".") mode_v = sts_pkg::M_DOT;
          else if (!sts_pkg::digit_byte(c)) begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        sts_pkg::M_DOT: begin
          if (sts_pkg::digit_byte(c)) mode_v = sts_pkg::M_FRAC;
          else begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        sts_pkg::M_FRAC: begin
          if (!sts_pkg::digit_byte(c)) begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        sts_pkg::M_IDENT: begin
          if (sts_pkg::alpha_byte(c) || sts_pkg::digit_byte(c))
            node_v = sts_pkg::trie_next(node_r, c);
          else begin do_flush = 1'b1; do_idle = 1'b1; end
        end
        default: do_idle = 1'b1;
      endcase
      if (pos_r < POS_MAX) pos_v = pos_r + P'(1);
    end

    // Emit the token or tokens that were pending before this byte.
    if (do_flush) begin
      case (mode_r)
        sts_pkg::M_SLASH: begin
          bundle.tok[n] = mk(sts_pkg::T_SLASH, ls_r, (P+1)'(1), sts_pkg::EK_NONE, 8'd0, ln_v);
          n = n + 2'd1;
        end
        sts_pkg::M_BANG, sts_pkg::M_EQUAL, sts_pkg::M_LESS, sts_pkg::M_GREATER: begin
          case (mode_r)
            sts_pkg::M_BANG:  k = sts_pkg::T_BANG;
            sts_pkg::M_EQUAL: k = sts_pkg::T_EQUAL;
            sts_pkg::M_LESS:  k = sts_pkg::T_LESS;
            default:          k = sts_pkg::T_GREATER;
          endcase
          bundle.tok[n] = mk(k, ls_r, (P+1)'(1), sts_pkg::EK_NONE, 8'd0, ln_v);
          n = n + 2'd1;
        end
        sts_pkg::M_INT, sts_pkg::M_FRAC: begin
          bundle.tok[n] = mk(sts_pkg::T_NUMBER, ls_r, span(ls_r, pos_r),
                             sts_pkg::EK_NONE, 8'd0, ln_v);
          n = n + 2'd1;
        end
        sts_pkg::M_DOT: begin
          // A number followed by a lone dot splits into two tokens.
          d = (pos_r > ls_r) ? pos_r - P'(1) : ls_r;
          bundle.tok[n] = mk(sts_pkg::T_NUMBER, ls_r, span(ls_r, d),
                             sts_pkg::EK_NONE, 8'd0, ln_v);
          n = n + 2'd1;
          bundle.tok[n] = mk(sts_pkg::T_DOT, d, (P+1)'(1), sts_pkg::EK_NONE, 8'd0, ln_v);
          n = n + 2'd1;
        end
        sts_pkg::M_IDENT: begin
          k = sts_pkg::accept_type(node_r);
          bundle.tok[n] = mk((k != 6'd0) ? k : sts_pkg::T_IDENT, ls_r, span(ls_r, pos_r),
                             sts_pkg::EK_NONE, 8'd0, ln_v);
          n = n + 2'd1;
        end
        sts_pkg::M_STRING: begin
          bundle.tok[n] = mk(sts_pkg::T_ERROR, ls_r, span(ls_r, pos_r),
                             sts_pkg::EK_STRING, 8'd0, ln_v);
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_v = sts_pkg::M_IDLE;
      node_v = sts_pkg::TRIE_ROOT;
    end

    // Scan the current byte with nothing pending.
    if (do_idle) begin
      mode_v = sts_pkg::M_IDLE;
      node_v = sts_pkg::TRIE_ROOT;
      ls_v   = pos_r;
      k      = 6'd0;
      if (c == "\n") begin
        if (ln_v < POS_MAX) ln_v = ln_v + P'(1);
      end else if (sts_pkg::alpha_byte(c)) begin
        mode_v = sts_pkg::M_IDENT;
        node_v = sts_pkg::trie_next(sts_pkg::TRIE_ROOT, c);
      end else if (sts_pkg::digit_byte(c)) begin
        mode_v = sts_pkg::M_INT;
      end else if (c != " " && c != "\r") begin
        case (c)
          "(":     k = sts_pkg::T_LPAREN;
          ")":     k = sts_pkg::T_RPAREN;
          "{":     k = sts_pkg::T_LBRACE;
          "}":     k = sts_pkg::T_RBRACE;
          ",":     k = sts_pkg::T_COMMA;
          ".":     k = sts_pkg::T_DOT;
          "-":     k = sts_pkg::T_MINUS;
          "+":     k = sts_pkg::T_PLUS;
          ";":     k = sts_pkg::T_SEMI;
          "*":     k = sts_pkg::T_STAR;
          "/":     mode_v = sts_pkg::M_SLASH;
          "!":     mode_v = sts_pkg::M_BANG;
          "=":     mode_v = sts_pkg::M_EQUAL;
          "<":     mode_v = sts_pkg::M_LESS;
          ">":     mode_v = sts_pkg::M_GREATER;
          "\"":    mode_v = sts_pkg::M_STRING;
          default: k = sts_pkg::T_ERROR;
        endcase
        if (k == sts_pkg::T_ERROR) begin
          bundle.tok[n] = mk(sts_pkg::T_ERROR, pos_r, (P+1)'(1), sts_pkg::EK_CHAR, c, ln_v);
          n = n + 2'd1;
        end else if (mode_v == sts_pkg::M_IDLE) begin
          bundle.tok[n] = mk(k, pos_r, (P+1)'(1), sts_pkg::EK_NONE, 8'd0, ln_v);
          n = n + 2'd1;
        end
      end
    end

    if (eos) begin
      bundle.tok[n] = mk(sts_pkg::T_EOF, pos_r, '0, sts_pkg::EK_NONE, 8'd0, ln_v);
      n = n + 2'd1;
      eof_v  = 1'b1;
      mode_v = sts_pkg::M_IDLE;
      node_v = sts_pkg::TRIE_ROOT;
    end
    bundle.cnt = n;
    push = acc && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sts_pkg::M_IDLE;
      node_r <= sts_pkg::TRIE_ROOT;
      ls_r   <= '0;
      pos_r  <= '0;
      line_r <= P'(1);
      eof_r  <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_v;
      node_r <= node_v;
      ls_r   <= ls_v;
      pos_r  <= pos_v;
      line_r <= ln_v;
      eof_r  <= eof_v;
    end
  end

endmodule
`default_nettype wire

[rtl/sts_queue.sv]
// Short bundle queue between the scanner front end and the token serializer.
// Depends on sts_pkg.
`default_nettype none
module sts_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire sts_pkg::bundle_t wdata,
  input  wire logic             pop,
  output sts_pkg::bundle_t      rdata,
  output logic                  full,
  output logic                  nempty
);

  sts_pkg::bundle_t mem_r [sts_pkg::QDEPTH];
  logic [sts_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [sts_pkg::QPTR_W:0]   cnt_r;

  assign full   = cnt_r == (sts_pkg::QPTR_W+1)'(sts_pkg::QDEPTH);
  assign nempty = cnt_r != '0;
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + (sts_pkg::QPTR_W)'(1);
      if (pop)  rp_r <= rp_r + (sts_pkg::QPTR_W)'(1);
      cnt_r <= cnt_r + (sts_pkg::QPTR_W+1)'(push) - (sts_pkg::QPTR_W+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("bundle queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !nempty))
    else $error("bundle queue read while empty");
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n) push |=> nempty)
    else $error("bundle queue empty after a write");
  a_bundle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
      nempty |-> rdata.cnt != 2'd0)
    else $error("queued bundle holds no token");
`endif

endmodule
`default_nettype wire

[rtl/sts_back.sv]
// Token serializer: pops bundles and drives one token per cycle while out_stall
// is low, through an output register. Depends on sts_pkg.
`default_nettype none
module sts_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sts_pkg::bundle_t head,
  input  wire logic             head_valid,
  output logic                  pop,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output sts_pkg::tok_t         out_tok,
  output logic                  out_last
);

  logic [1:0]    idx_r;
  logic          valid_r, last_r;
  sts_pkg::tok_t tok_r;
  logic          load, is_last;

  assign load    = head_valid && (!valid_r || !out_stall);
  assign is_last = idx_r == (head.cnt - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= head.tok[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

[tb/tb_script_token_scanner_unit.sv]
// Self-checking testbench for script_token_scanner_unit: streams source bytes, predicts
// the token stream in-line and compares every token that comes out.
// Depends on sts_pkg and the scanner RTL.
`default_nettype none
module tb_script_token_scanner_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned POS_MAX = (64'd1 << 24) - 1;

  typedef struct {
    logic [7:0] c;
    logic       eos;
  } src_item_t;

  typedef struct {
    logic [5:0]  typ;
    logic [23:0] st;
    logic [23:0] ln;
    logic [23:0] li;
    logic [1:0]  ek;
    logic [7:0]  bc;
    logic        last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char_byte = 8'd0;
  logic in_end_of_source = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_token_type;
  logic [23:0] out_token_start, out_token_length, out_token_line;
  logic [1:0] out_error_kind;
  logic [7:0] out_bad_char;
  logic out_last_of_run;

  script_token_scanner_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_byte(in_char_byte), .in_end_of_source(in_end_of_source),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_type(out_token_type), .out_token_start(out_token_start),
    .out_token_length(out_token_length), .out_token_line(out_token_line),
    .out_error_kind(out_error_kind), .out_bad_char(out_bad_char),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  src_item_t byte_queue[$];
  token_t    token_fifo[$];
  token_t    burst[$];
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        errors = 0;
  bit        in_took = 1'b0;

  // Scanner shadow state.
  sts_pkg::mode_t  md = sts_pkg::M_IDLE;
  logic [5:0]      node = sts_pkg::TRIE_ROOT;
  longint unsigned lstart = 0, bpos = 0, lcount = 1;
  bit              eof_done = 1'b0;

  function automatic logic [23:0] sat24(longint unsigned v);
    return (v > POS_MAX) ? POS_MAX[23:0] : v[23:0];
  endfunction

  function automatic longint unsigned gap(longint unsigned a, longint unsigned b);
    return (b >= a) ? b - a : 0;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] walk(logic [5:0] n, logic [7:0] c);
    logic [5:0] r;
    r = 6'd0;
    if (n != 6'd0)
      for (int i = 2; i < sts_pkg::NODES; i++)
        if (sts_pkg::UP_NODE[i] == n && sts_pkg::UP_CHAR[i] == c) r = 6'(i);
    return r;
  endfunction

  // Keyword codes follow the order and ... while at the accepting trie nodes.
  function automatic logic [5:0] keyword_code(logic [5:0] n);
    case (n)
      6'd4:  return 6'd22;
      6'd9:  return 6'd23;
      6'd13: return 6'd24;
      6'd18: return 6'd25;
      6'd20: return 6'd26;
      6'd22: return 6'd27;
      6'd24: return 6'd28;
      6'd27: return 6'd29;
      6'd29: return 6'd30;
      6'd34: return 6'd31;
      6'd40: return 6'd32;
      6'd45: return 6'd33;
      6'd49: return 6'd34;
      6'd52: return 6'd35;
      6'd55: return 6'd36;
      6'd60: return 6'd37;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] op_code(sts_pkg::mode_t m);
    case (m)
      sts_pkg::M_BANG:  return sts_pkg::T_BANG;
      sts_pkg::M_EQUAL: return sts_pkg::T_EQUAL;
      sts_pkg::M_LESS:  return sts_pkg::T_LESS;
      default:          return sts_pkg::T_GREATER;
    endcase
  endfunction

  task automatic add_token(logic [5:0] typ, longint unsigned s, longint unsigned l,
                           logic [1:0] ek, logic [7:0] bc);
    token_t t;
    if (burst.size() < 3) begin
      t = '{typ, sat24(s), sat24(l), sat24(lcount), ek, bc, 1'b0};
      burst.push_back(t);
    end
  endtask

  task automatic go_idle();
    md = sts_pkg::M_IDLE;
    node = sts_pkg::TRIE_ROOT;
  endtask

  task automatic scan_fresh(logic [7:0] c, longint unsigned p);
    go_idle();
    lstart = p;
    if (c == " " || c == "\r") return;
    if (c == "\n") begin
      if (lcount < POS_MAX) lcount++;
      return;
    end
    if (letter(c)) begin
      md = sts_pkg::M_IDENT;
      node = walk(sts_pkg::TRIE_ROOT, c);
      return;
    end
    if (digit(c)) begin
      md = sts_pkg::M_INT;
      return;
    end
    case (c)
      "(": add_token(sts_pkg::T_LPAREN, p, 1, sts_pkg::EK_NONE, 8'd0);
      ")": add_token(sts_pkg::T_RPAREN, p, 1, sts_pkg::EK_NONE, 8'd0);
      "{": add_token(sts_pkg::T_LBRACE, p, 1, sts_pkg::EK_NONE, 8'd0);
      "}": add_token(sts_pkg::T_RBRACE, p, 1, sts_pkg::EK_NONE, 8'd0);
      ",": add_token(sts_pkg::T_COMMA, p, 1, sts_pkg::EK_NONE, 8'd0);
      ".": add_token(sts_pkg::T_DOT, p, 1, sts_pkg::EK_NONE, 8'd0);
      "-": add_token(sts_pkg::T_MINUS, p, 1, sts_pkg::EK_NONE, 8'd0);
      "+": add_token(sts_pkg::T_PLUS, p, 1, sts_pkg::EK_NONE, 8'd0);
      ";": add_token(sts_pkg::T_SEMI, p, 1, sts_pkg::EK_NONE, 8'd0);
      "*": add_token(sts_pkg::T_STAR, p, 1, sts_pkg::EK_NONE, 8'd0);
      "/": md = sts_pkg::M_SLASH;
      "!": md = sts_pkg::M_BANG;
      "=": md = sts_pkg::M_EQUAL;
      "<": md = sts_pkg::M_LESS;
      ">": md = sts_pkg::M_GREATER;
      "\"": md = sts_pkg::M_STRING;
      default: add_token(sts_pkg::T_ERROR, p, 1, sts_pkg::EK_CHAR, c);
    endcase
  endtask

  // Emits whatever token or tokens are pending before offset p.
  task automatic flush_lexeme(longint unsigned p);
    longint unsigned s, d;
    logic [5:0] k;
    s = lstart;
    case (md)
      sts_pkg::M_SLASH: add_token(sts_pkg::T_SLASH, s, 1, sts_pkg::EK_NONE, 8'd0);
      sts_pkg::M_BANG, sts_pkg::M_EQUAL, sts_pkg::M_LESS, sts_pkg::M_GREATER:
        add_token(op_code(md), s, 1, sts_pkg::EK_NONE, 8'd0);
      sts_pkg::M_INT, sts_pkg::M_FRAC:
        add_token(sts_pkg::T_NUMBER, s, gap(s, p), sts_pkg::EK_NONE, 8'd0);
      sts_pkg::M_DOT: begin
        d = (p > s) ? p - 1 : s;
        add_token(sts_pkg::T_NUMBER, s, gap(s, d), sts_pkg::EK_NONE, 8'd0);
        add_token(sts_pkg::T_DOT, d, 1, sts_pkg::EK_NONE, 8'd0);
      end
      sts_pkg::M_IDENT: begin
        k = keyword_code(node);
        add_token((k != 6'd0) ? k : sts_pkg::T_IDENT, s, gap(s, p), sts_pkg::EK_NONE, 8'd0);
      end
      sts_pkg::M_STRING:
        add_token(sts_pkg::T_ERROR, s, gap(s, p), sts_pkg::EK_STRING, 8'd0);
      default: ;
    endcase
    go_idle();
  endtask

  task automatic scan_item(logic [7:0] c, logic eos);
    longint unsigned p;
    p = bpos;
    burst.delete();
    if (eos) begin
      if (!eof_done) flush_lexeme(p);
      add_token(sts_pkg::T_EOF, p, 0, sts_pkg::EK_NONE, 8'd0);
      eof_done = 1'b1;
      go_idle();
    end else if (!eof_done) begin
      case (md)
        sts_pkg::M_SLASH:
          if (c == "/") md = sts_pkg::M_COMMENT;
          else begin
            flush_lexeme(p);
            scan_fresh(c, p);
          end
        sts_pkg::M_COMMENT: if (c == "\n") scan_fresh(c, p);
        sts_pkg::M_BANG, sts_pkg::M_EQUAL, sts_pkg::M_LESS, sts_pkg::M_GREATER:
          if (c == "=") begin
            add_token(op_code(md) + 6'd1, lstart, gap(lstart, p) + 1, sts_pkg::EK_NONE,
                      8'd0);
            go_idle();
          end else begin
            flush_lexeme(p);
            scan_fresh(c, p);
          end
        sts_pkg::M_STRING:
          if (c == "\"") begin
            add_token(sts_pkg::T_STRING, lstart, gap(lstart, p) + 1, sts_pkg::EK_NONE,
                      8'd0);
            go_idle();
          end else if (c == "\n" && lcount < POS_MAX) lcount++;
        sts_pkg::M_INT:
          if (c == ".") md = sts_pkg::M_DOT;
          else if (!digit(c)) begin
            flush_lexeme(p);
            scan_fresh(c, p);
          end
        sts_pkg::M_DOT:
          if (digit(c)) md = sts_pkg::M_FRAC;
          else begin
            flush_lexeme(p);
            scan_fresh(c, p);
          end
        sts_pkg::M_FRAC:
          if (!digit(c)) begin
            flush_lexeme(p);
            scan_fresh(c, p);
          end
        sts_pkg::M_IDENT:
          if (letter(c) || digit(c)) node = walk(node & 6'h3f, c);
          else begin
            flush_lexeme(p);
            scan_fresh(c, p);
          end
        default: scan_fresh(c, p);
      endcase
      if (bpos < POS_MAX) bpos++;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) token_fifo.push_back(burst[i]);
  endtask

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Sender: a new item is offered only once the previous one has been taken.
  always @(negedge clk) begin
    src_item_t it;
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          it = byte_queue.pop_front();
          in_valid <= 1'b1;
          in_char_byte <= it.c;
          in_end_of_source <= it.eos;
        end else begin
          in_valid <= 1'b0;
          in_char_byte <= 8'($urandom);
          in_end_of_source <= 1'($urandom);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    token_t e;
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) scan_item(in_char_byte, in_end_of_source);
    if (rst_n && out_valid && !out_stall) begin
      if (token_fifo.size() == 0) report("token with none expected");
      else begin
        e = token_fifo.pop_front();
        if (out_token_type !== e.typ || out_token_start !== e.st ||
            out_token_length !== e.ln || out_token_line !== e.li ||
            out_error_kind !== e.ek || out_bad_char !== e.bc ||
            out_last_of_run !== e.last)
          report($sformatf("got %0d/%0d/%0d/%0d/%0d/%0d/%0d exp %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                           out_token_type, out_token_start, out_token_length,
                           out_token_line, out_error_kind, out_bad_char,
                           out_last_of_run, e.typ, e.st, e.ln, e.li, e.ek, e.bc,
                           e.last));
      end
    end
  end

  task automatic push_bytes(string s);
    for (int i = 0; i < s.len(); i++) byte_queue.push_back('{s[i], 1'b0});
  endtask

  function automatic string rand_word(int n);
    string s, pool;
    s = "";
    pool = "abcdefghijklmnopqrstuvwxyzABCXYZ_0123456789";
    for (int i = 0; i < n; i++)
      s = {s, string'(pool[(i == 0) ? $urandom_range(32) : $urandom_range(42)])};
    return s;
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  // One lexeme with random content, mostly well formed, followed by a separator or by nothing.
  task automatic push_lexeme();
    string words[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                         "or", "print", "return", "super", "this", "true", "var",
                         "while"};
    string ops = "(){},.-+;*/!=<>";
    string s;
    case ($urandom_range(11))
      0, 1: s = words[$urandom_range(15)];
      2: s = {words[$urandom_range(15)], rand_word($urandom_range(0, 2))};
      3: s = rand_word($urandom_range(1, 6));
      4: s = rand_digits($urandom_range(1, 4));
      5: s = {rand_digits($urandom_range(1, 3)), ".", rand_digits($urandom_range(1, 3))};
      6: s = {rand_digits($urandom_range(1, 2)), ".", string'(ops[$urandom_range(14)])};
      7: s = {"\"", rand_word($urandom_range(0, 3)), ($urandom_range(1) ? "\n" : " "),
              "\""};
      8: s = {"//", rand_word($urandom_range(0, 4)), "\n"};
      9: s = {string'(ops[$urandom_range(14)]), ($urandom_range(1) ? "=" : "")};
      10: s = {string'(8'($urandom))};
      default: s = {string'(8'($urandom_range(128, 255))), "\t"};
    endcase
    case ($urandom_range(5))
      0: s = {s, "\n"};
      1: s = {s, "\r"};
      2: ;
      default: s = {s, " "};
    endcase
    push_bytes(s);
  endtask

  task automatic fill_bytes(int count);
    int target;
    target = byte_queue.size() + count;
    while (byte_queue.size() < target) push_lexeme();
  endtask

  task automatic drain_sender();
    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a keyword, two-character operators, number then dot, tab, byte 0,
    // top-bit bytes, a string across lines and a comment.
    push_bytes("while(1.5)!=x<= >=1.(\t");
    byte_queue.push_back('{8'h00, 1'b0});
    byte_queue.push_back('{8'hff, 1'b0});
    byte_queue.push_back('{8'h80, 1'b0});
    push_bytes("\"a\nb\"//c\n==/ ");
    fill_bytes(35);
    drain_sender();

    idle_pct = 47;
    fill_bytes(30);
    drain_sender();
    // Hold off until every outstanding token has come back.
    while (token_fifo.size() != 0) @(posedge clk);
    fill_bytes(30);
    drain_sender();

    idle_pct = 0;
    stall_pct = 47;
    fill_bytes(55);
    drain_sender();

    idle_pct = 6;
    stall_pct = 6;
    fill_bytes(50);
    // End in an open string, then bytes after EOF are ignored and a second end
    // marker gives another EOF.
    push_bytes("\"ab\nc");
    byte_queue.push_back('{8'($urandom), 1'b1});
    push_bytes("x(");
    byte_queue.push_back('{8'($urandom), 1'b1});
    drain_sender();
    while (token_fifo.size() != 0) @(posedge clk);
    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (errors == 0 && token_fifo.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
